/* design/cism_pkg.sv */
// Shared types, register codes and the letter-fold helper for the
// case-insensitive substring matcher. No dependencies.

package cism_pkg;

    localparam int MATCH_START_W = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int NEEDLE_LEN_W  = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NEEDLE_LOW    = 2'd0,
        REG_NEEDLE_HIGH   = 2'd1,
        REG_NEEDLE_LENGTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       text_last;
    } text_req_t;

    typedef struct packed {
        logic                     match_found;
        logic [MATCH_START_W-1:0] match_start;
        logic                     text_done;
    } match_rsp_t;

    // Window cell control: advance the window, or drop it at end of text.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    // Fold ASCII upper case letters to lower case.
    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

/* design/case_insensitive_substring_match.sv */
// Top level of the case-insensitive substring matcher: configuration
// registers, a row of cism_cell window cells and the result register.
// Depends on cism_pkg and cism_cell.
//
// Usage:
//   Write the needle bytes (registers 0 and 1) and its length (register 2)
//   through cfg_write/cfg_index/cfg_data while no request is in flight.
//   Stream text on in_data, one byte per request; text_last closes a text.
//   Each request produces exactly one response on out_data, registered when
//   it is taken, in order. match_found flags the first match of a text, at
//   its final byte, with match_start the offset of its first byte.
//   Throughput is one request per cycle: the window of MAX_NEEDLE-1 cells
//   shifts and compares in the same cycle the byte arrives, and the single
//   response register is reloaded whenever it is empty or being taken.
//   When out_ready is low the response holds and in_ready drops until it is
//   taken. Reset empties the window, clears the needle to length zero (no
//   matching), zeroes the text position and drops any pending response.
//   No clearing pass is needed after reset.

module case_insensitive_substring_match
    import cism_pkg::*;
#(
    parameter int MAX_NEEDLE    = 16,
    parameter int POSITION_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  text_req_t              in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output match_rsp_t             out_data
);

    localparam int LW    = $clog2(MAX_NEEDLE + 1);
    localparam int IW    = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int NCELL = MAX_NEEDLE - 1;
    localparam int OKW   = (NCELL > 0) ? NCELL : 1;
    localparam int WIDE  = (POSITION_BITS > MATCH_START_W) ? POSITION_BITS : MATCH_START_W;
    localparam logic [POSITION_BITS-1:0] POS_TOP = '1;

    logic [MAX_NEEDLE-1:0][7:0] needle_reg;
    logic [NEEDLE_LEN_W-1:0]    len_reg;
    logic [POSITION_BITS-1:0]   pos_reg;
    logic [POSITION_BITS-1:0]   pos_next;
    logic                       reported_reg;
    logic                       reported_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    match_rsp_t                 out_data_reg;
    match_rsp_t                 rsp_next;

    logic                       take;
    logic [7:0]                 byte_f;
    logic                       byte_zero;
    logic [LW-1:0]              len_eff;
    logic [LW-1:0]              head_sel;
    logic                       head_ok;
    logic                       hit;
    logic [OKW-1:0]             cell_ok;
    logic [POSITION_BITS-1:0]   len_m1;
    logic [POSITION_BITS-1:0]   start_pos;
    logic [WIDE-1:0]            start_wide;
    cell_ctl_t                  ctl;

    // Needle bytes are stored already folded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needle_reg <= '0;
            len_reg    <= '0;
        end
        else if (cfg_write)
        begin
            for (int i = 0; i < MAX_NEEDLE; i++)
            begin
                if (i < 8 && cfg_index == REG_NEEDLE_LOW)
                begin
                    needle_reg[i] <= fold_byte(cfg_data[8*(i%8) +: 8]);
                end
                else if (i >= 8 && cfg_index == REG_NEEDLE_HIGH)
                begin
                    needle_reg[i] <= fold_byte(cfg_data[8*(i%8) +: 8]);
                end
            end
            if (cfg_index == REG_NEEDLE_LENGTH)
            begin
                len_reg <= cfg_data[NEEDLE_LEN_W-1:0];
            end
        end
    end

    always_comb
    begin
        take      = in_valid && in_ready;
        byte_f    = fold_byte(in_data.text_byte);
        byte_zero = (byte_f == 8'h00);
        if ({{(32-NEEDLE_LEN_W){1'b0}}, len_reg} > 32'(MAX_NEEDLE))
        begin
            len_eff = LW'(MAX_NEEDLE);
        end
        else
        begin
            len_eff = LW'(len_reg);
        end
        head_sel = len_eff - LW'(1);
        head_ok  = (len_eff != '0) && (byte_f == needle_reg[head_sel[IW-1:0]]);
        hit      = !byte_zero && !reported_reg && head_ok && (&cell_ok);

        ctl.clear = take && in_data.text_last;
        ctl.shift = take && !byte_zero && !reported_reg;
    end

    generate
        if (NCELL == 0)
        begin : g_no_cells
            assign cell_ok = '1;
        end
        else
        begin : g_cells
            logic [NCELL-1:0][7:0] chain_byte;
            logic [NCELL-1:0]      chain_valid;

            for (genvar k = 0; k < NCELL; k++)
            begin : g_cell
                cism_cell #(
                    .MAX_NEEDLE (MAX_NEEDLE),
                    .CELL_IDX   (k)
                ) u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctl        (ctl),
                    .din        ((k == 0) ? byte_f : chain_byte[(k == 0) ? 0 : k-1]),
                    .din_valid  ((k == 0) ? 1'b1 : chain_valid[(k == 0) ? 0 : k-1]),
                    .needle     (needle_reg),
                    .len        (len_eff),
                    .dout       (chain_byte[k]),
                    .dout_valid (chain_valid[k]),
                    .ok         (cell_ok[k])
                );
            end
        end
    endgenerate

    // Match start: position less the needle length minus one, clamped.
    always_comb
    begin
        len_m1    = POSITION_BITS'(len_eff) - POSITION_BITS'(1);
        start_pos = pos_reg - len_m1;
        if (pos_reg < len_m1)
        begin
            start_pos = '0;
        end
        start_wide = WIDE'(start_pos);

        rsp_next.match_found = hit;
        rsp_next.text_done   = in_data.text_last;
        rsp_next.match_start = '0;
        if (hit)
        begin
            if (start_wide > WIDE'(16'hFFFF))
            begin
                rsp_next.match_start = 16'hFFFF;
            end
            else
            begin
                rsp_next.match_start = start_wide[MATCH_START_W-1:0];
            end
        end
    end

    always_comb
    begin
        pos_next      = pos_reg;
        reported_next = reported_reg;
        if (take)
        begin
            if (in_data.text_last)
            begin
                pos_next      = '0;
                reported_next = 1'b0;
            end
            else
            begin
                if (pos_reg != POS_TOP)
                begin
                    pos_next = pos_reg + POSITION_BITS'(1);
                end
                if (byte_zero || hit)
                begin
                    reported_next = 1'b1;
                end
            end
        end

        out_valid_next = out_valid_reg;
        if (in_ready)
        begin
            out_valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= rsp_next;
        end
    end

    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Once a text is closed no further match may be flagged for it.
    a_no_hit_when_closed: assert property (@(posedge clk) disable iff (!rst_n)
        reported_reg |-> !hit)
        else $error("match flagged after search closed");

    // End of text returns position and search state to zero.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && in_data.text_last) |=> (pos_reg == '0) && !reported_reg)
        else $error("text state not cleared after last byte");

    // A zero byte closes the search for the rest of the text.
    a_zero_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (take && byte_zero && !in_data.text_last) |=> reported_reg)
        else $error("zero byte did not close the search");

    // A flagged match before the final byte of a text closes the search.
    a_hit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (take && hit && !in_data.text_last) |=> reported_reg && out_data.match_found)
        else $error("match did not close the search");

endmodule

/* design/cism_cell.sv */
// One window cell: holds one folded text byte and its valid flag, hands it on
// to the next cell and compares it with the needle byte aligned to it.
// Depends on cism_pkg.

module cism_cell
    import cism_pkg::*;
#(
    parameter int MAX_NEEDLE = 16,
    parameter int CELL_IDX   = 0
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cell_ctl_t                              ctl,
    input  logic [7:0]                             din,
    input  logic                                   din_valid,
    input  logic [MAX_NEEDLE-1:0][7:0]             needle,
    input  logic [$clog2(MAX_NEEDLE+1)-1:0]        len,
    output logic [7:0]                             dout,
    output logic                                   dout_valid,
    output logic                                   ok
);

    localparam int LW = $clog2(MAX_NEEDLE + 1);
    localparam int IW = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;

    logic [7:0]    byte_reg;
    logic          valid_reg;
    logic          valid_next;
    logic          active;
    logic [LW-1:0] sel;
    logic [7:0]    expect_byte;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.shift)
        begin
            valid_next = din_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            byte_reg <= din;
        end
    end

    // This cell holds the byte that sits len-2-CELL_IDX places into the needle.
    always_comb
    begin
        active      = ({1'b0, len} >= (LW + 1)'(CELL_IDX + 2));
        sel         = len - LW'(CELL_IDX + 2);
        expect_byte = needle[sel[IW-1:0]];
        ok          = !active || (valid_reg && (byte_reg == expect_byte));
    end

    assign dout       = byte_reg;
    assign dout_valid = valid_reg;

endmodule

/* sim/tb_case_insensitive_substring_match.sv */
// Self-checking bench for case_insensitive_substring_match: a directed table,
// then randomised texts under several needle settings and handshake stalls.
// Depends on cism_pkg and the matcher RTL.

module tb_case_insensitive_substring_match;
    timeunit 1ns;
    timeprecision 1ps;

    import cism_pkg::*;

    localparam int MAX_NEEDLE     = 16;
    localparam int WINDOW         = MAX_NEEDLE - 1;
    localparam int PHASE_ITEMS    = 105;
    localparam int HOLD_OFF       = 60;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [7:0]  text_char;
        logic        last;
        logic        known;
        logic        found;
        logic [15:0] start;
        logic        done;
    } stim_row_t;

    // Needle "aBc", length 3. Rows with known set carry their own result.
    localparam stim_row_t DIRECTED_ROWS [24] = '{
        '{8'h78, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0},  // x
        '{8'h41, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0},  // A
        '{8'h62, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0},  // b
        '{8'h43, 1'b0, 1'b1, 1'b1, 16'd1, 1'b0},  // C: first match, starts at 1
        '{8'h61, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0},  // second match is not reported
        '{8'h62, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0},
        '{8'h63, 1'b1, 1'b1, 1'b0, 16'd0, 1'b1},
        '{8'h61, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0},
        '{8'h00, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0},  // zero byte closes the search
        '{8'h62, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0},
        '{8'h63, 1'b1, 1'b1, 1'b0, 16'd0, 1'b1},
        '{8'h41, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0},  // text shorter than the needle
        '{8'h62, 1'b1, 1'b1, 1'b0, 16'd0, 1'b1},
        '{8'hFF, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h40, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0},  // just below the upper case range
        '{8'h5B, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0},  // just above it
        '{8'h5A, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h01, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h80, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h61, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0},
        '{8'h42, 1'b0, 1'b1, 1'b0, 16'd0, 1'b0},
        '{8'h63, 1'b1, 1'b1, 1'b1, 16'd6, 1'b1},
        '{8'h78, 1'b0, 1'b0, 1'b0, 16'd0, 1'b0},
        '{8'h00, 1'b1, 1'b1, 1'b0, 16'd0, 1'b1}   // zero byte as final byte
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    text_req_t              in_data;
    logic                   out_valid;
    logic                   out_ready;
    match_rsp_t             out_data;

    // Needle settings as seen by the matcher
    logic [127:0]           needle_pattern;
    logic [4:0]             needle_len;

    // Search state of the current text
    logic [7:0]             text_window [WINDOW];
    int                     window_fill;
    logic [15:0]            text_pos;
    logic                   search_closed;

    match_rsp_t             expected_results [$];
    match_rsp_t             oldest;
    int                     send_idle_pct;
    int                     recv_stall_pct;
    logic                   hold_request;
    int                     items_sent;
    int                     texts_sent;
    int                     matches_seen;
    int                     failures;
    int                     quiet_cycles;

    case_insensitive_substring_match u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic [7:0] random_case(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1) ? c - 8'h20 : c;
    endfunction

    function automatic int active_len();
        return (needle_len > MAX_NEEDLE) ? MAX_NEEDLE : int'(needle_len);
    endfunction

    function automatic void restart_text();
        foreach (text_window[k])
            text_window[k] = 8'h00;
        window_fill = 0;
        text_pos = '0;
        search_closed = 1'b0;
    endfunction

    function automatic match_rsp_t predict_match(input text_req_t req);
        logic [7:0] c;
        int         len;
        int         k;
        logic       same;
        match_rsp_t r;
        c = to_lower(req.text_byte);
        len = active_len();
        r = '0;
        r.text_done = req.text_last;
        if (c == 8'h00)
            search_closed = 1'b1;
        else if (!search_closed)
        begin
            if (len != 0 && window_fill + 1 >= len)
            begin
                same = (to_lower(needle_pattern[8*(len-1) +: 8]) == c);
                for (k = 1; k < len; k++)
                    if (to_lower(needle_pattern[8*(len-1-k) +: 8]) != text_window[k-1])
                        same = 1'b0;
                if (same)
                begin
                    r.match_found = 1'b1;
                    r.match_start = (text_pos < len - 1) ? 16'd0 : 16'(text_pos - (len - 1));
                    search_closed = 1'b1;
                end
            end
            for (k = WINDOW - 1; k > 0; k--)
                text_window[k] = text_window[k-1];
            text_window[0] = c;
            if (window_fill < WINDOW)
                window_fill++;
        end
        // position holds at its top value
        if (text_pos != 16'hFFFF)
            text_pos++;
        if (req.text_last)
            restart_text();
        return r;
    endfunction

    function automatic logic [63:0] letter_word();
        logic [63:0] w;
        int          i;
        for (i = 0; i < 8; i++)
            w[8*i +: 8] = random_case(8'($urandom_range(8'h61, 8'h7A)));
        return w;
    endfunction

    function automatic logic [7:0] noise_char();
        int         pick;
        int         idx;
        logic [7:0] c;
        pick = $urandom_range(0, 39);
        if (pick == 0)
            c = 8'h00;
        else if (pick < 7)
            c = 8'($urandom_range(1, 255));
        else if (pick < 23 && active_len() != 0)
        begin
            idx = $urandom_range(0, active_len() - 1);
            c = random_case(to_lower(needle_pattern[8*idx +: 8]));
        end
        else
            c = random_case(8'($urandom_range(8'h61, 8'h7A)));
        return c;
    endfunction

    task automatic push_item(input logic [7:0] c, input logic last, input logic known,
                             input match_rsp_t want);
        text_req_t  req;
        match_rsp_t predicted;
        req.text_byte = c;
        req.text_last = last;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_match(req);
        expected_results.push_back(known ? want : predicted);
        items_sent++;
    endtask

    // Prefix noise, then a whole or broken needle or plain noise, then a tail.
    task automatic send_text();
        logic [7:0] chars [$];
        int         kind;
        int         n;
        int         i;
        kind = $urandom_range(0, 9);
        repeat ($urandom_range(0, 5))
            chars.push_back(noise_char());
        if (kind < 6)
            n = active_len();
        else if (kind < 8)
            n = (active_len() > 1) ? $urandom_range(0, active_len() - 1) : 0;
        else
            n = 0;
        for (i = 0; i < n; i++)
            chars.push_back(random_case(to_lower(needle_pattern[8*i +: 8])));
        repeat ((kind >= 8) ? $urandom_range(1, 8) : $urandom_range(0, 3))
            chars.push_back(noise_char());
        if (chars.size() == 0)
            chars.push_back(noise_char());
        foreach (chars[k])
            push_item(chars[k], k == chars.size() - 1, 1'b0, '0);
        texts_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic load_needle(input logic [63:0] lo, input logic [63:0] hi,
                               input logic [4:0] len);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_NEEDLE_LOW;
        cfg_data <= lo;
        @(negedge clk);
        cfg_index <= REG_NEEDLE_HIGH;
        cfg_data <= hi;
        @(negedge clk);
        cfg_index <= REG_NEEDLE_LENGTH;
        cfg_data <= 64'(len);
        @(negedge clk);
        cfg_write <= 1'b0;
        needle_pattern = {hi, lo};
        needle_len = len;
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int   hold_left;
        logic hold_seen;
        hold_left = 0;
        hold_seen = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_seen)
            begin
                hold_seen = 1'b1;
                hold_left = HOLD_OFF;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (out_data.match_found)
                matches_seen++;
            if (expected_results.size() == 0)
            begin
                $error("result with nothing outstanding: %p", out_data);
                failures++;
            end
            else
            begin
                oldest = expected_results.pop_front();
                if (out_data.match_found !== oldest.match_found)
                begin
                    $error("match_found: expected %0d, got %0d",
                           oldest.match_found, out_data.match_found);
                    failures++;
                end
                if (out_data.match_start !== oldest.match_start)
                begin
                    $error("match_start: expected %0d, got %0d",
                           oldest.match_start, out_data.match_start);
                    failures++;
                end
                if (out_data.text_done !== oldest.text_done)
                begin
                    $error("text_done: expected %0d, got %0d",
                           oldest.text_done, out_data.text_done);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int         p;
        int         phase_start;
        idle_mode_t mode;
        match_rsp_t want;
        in_valid = 1'b0;
        in_data = '0;
        cfg_write = 1'b0;
        cfg_index = REG_NEEDLE_LOW;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b0;
        items_sent = 0;
        texts_sent = 0;
        needle_pattern = '0;
        needle_len = '0;
        restart_text();
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        load_needle(64'h0000_0000_0063_4261, 64'd0, 5'd3);
        foreach (DIRECTED_ROWS[r])
        begin
            want.match_found = DIRECTED_ROWS[r].found;
            want.match_start = DIRECTED_ROWS[r].start;
            want.text_done = DIRECTED_ROWS[r].done;
            push_item(DIRECTED_ROWS[r].text_char, DIRECTED_ROWS[r].last,
                      DIRECTED_ROWS[r].known, want);
        end
        drain();

        for (p = 0; p < 8; p++)
        begin
            mode = idle_mode_t'(p % 4);
            case (mode)
                IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SENDER:   begin send_idle_pct = 83; recv_stall_pct = 0;  end
                IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default:       begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            case (p)
                0: load_needle(letter_word(), letter_word(), 5'd3);
                1: load_needle(64'd0, 64'd0, 5'd0);
                2: load_needle(letter_word(), letter_word(), 5'd16);
                3: load_needle(letter_word(), letter_word(), 5'd31);
                4: load_needle(letter_word(), letter_word(), 5'd1);
                5: load_needle(letter_word() & ~64'hFF_0000, letter_word(), 5'd5);
                6: load_needle('1, '1, 5'd17);
                default: load_needle({$urandom, $urandom}, {$urandom, $urandom},
                                     5'($urandom_range(2, 8)));
            endcase
            // stall the output while the sender keeps going, so the input backs up
            if (p == 0)
                hold_request = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_text();
            drain();
        end

        repeat (4) @(negedge clk);
        $display("covered %0d bytes in %0d texts, %0d matches, eight needle settings",
                 items_sent, texts_sent, matches_seen);
        $display("plus empty, overlong and zero-holding needles under four idle patterns");
        if (failures == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
design/cism_pkg.sv
design/cism_cell.sv
design/case_insensitive_substring_match.sv
sim/tb_case_insensitive_substring_match.sv
